// ===== rtl/core/arpc_pkg.sv =====
// Shared types, widths and codes for the ARP cache table.
`default_nettype none
package arpc_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAMP_W = 64;
  localparam int SLOT_W  = 6;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [IP_W-1:0]  IP_ALL_ONES  = '1;
  localparam logic [MAC_W-1:0] MAC_ALL_ONES = '1;

  // Opcodes of an input transaction
  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // Register select, taken from paddr[2]
  localparam logic REG_LOCAL_IP    = 1'b0;
  localparam logic REG_SUBNET_MASK = 1'b1;

  typedef enum logic [2:0] {
    STAT_HIT      = 3'd0,
    STAT_BCAST    = 3'd1,
    STAT_MISS     = 3'd2,
    STAT_UPDATED  = 3'd3,
    STAT_INSERTED = 3'd4,
    STAT_EVICTED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/arp_cache_table_core.sv =====
// ARP cache: IPv4-to-MAC table with add/update and resolve transactions.
// Input channel (in_valid/in_ready) carries opcode, ip_address, mac_address
// and now_ticks; output channel (out_valid/out_ready) returns one result of
// status, mac_result and slot for every input transaction.
// Entries are filled from index 0 upwards and never removed, so a fill
// count marks the valid region of the table memory; evictions reuse slots.
// One transaction at a time: after acceptance the block reads the table
// memory through its single read port, one entry per cycle, comparing IP
// addresses and tracking the oldest stamp. The scan stops early on a hit,
// and a broadcast resolve skips the scan.
// The result sits in an output register; a new transaction is accepted
// while it waits. A stalled receiver holds the result, and the next one
// waits in the sequencer until the register is free.
// Synchronous reset empties the table (fill count to zero) and clears
// local_ip and subnet_mask, writable over the APB port at 0x0 and 0x4.
`default_nettype none
module arp_cache_table_core #(
  parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // APB configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [arpc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [arpc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [arpc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  // Input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            opcode,
  input  wire logic [arpc_pkg::IP_W-1:0]       ip_address,
  input  wire logic [arpc_pkg::MAC_W-1:0]      mac_address,
  input  wire logic [arpc_pkg::STAMP_W-1:0]    now_ticks,
  // Output channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [2:0]                      status,
  output logic      [arpc_pkg::MAC_W-1:0]      mac_result,
  output logic      [arpc_pkg::SLOT_W-1:0]     slot
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_FIN    = 4'b1000
  } state_t;

  state_t state;

  logic [arpc_pkg::IP_W-1:0] local_ip;
  logic [arpc_pkg::IP_W-1:0] subnet_mask;

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] scan_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;

  logic                         item_op;
  logic                         item_bcast;
  logic [arpc_pkg::IP_W-1:0]    item_ip;
  logic [arpc_pkg::MAC_W-1:0]   item_mac;
  logic [arpc_pkg::STAMP_W-1:0] item_now;

  logic                         found;
  logic [IDX_W-1:0]             found_idx;
  logic [arpc_pkg::STAMP_W-1:0] min_stamp;
  logic [IDX_W-1:0]             min_idx;

  arpc_pkg::status_t            res_status;
  logic [arpc_pkg::MAC_W-1:0]   res_mac;
  logic [arpc_pkg::SLOT_W-1:0]  res_slot;

  arpc_pkg::entry_t rd_data;
  arpc_pkg::entry_t wr_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  logic                      cfg_write;
  logic                      in_accept;
  logic                      issue;
  logic                      match;
  logic                      older;
  logic                      table_full;
  logic                      out_free;
  logic [arpc_pkg::IP_W-1:0] subnet_bcast;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      arpc_pkg::REG_LOCAL_IP:    prdata = local_ip;
      arpc_pkg::REG_SUBNET_MASK: prdata = subnet_mask;
      default:                   prdata = '0;
    endcase
  end

  assign subnet_bcast = local_ip | ~subnet_mask;
  assign in_ready     = (state == ST_IDLE);
  assign in_accept    = in_valid & in_ready;
  assign table_full   = (fill_count == CNT_FULL);
  assign out_free     = ~out_valid | out_ready;

  assign issue = (state == ST_SCAN) && (scan_idx < fill_count);
  assign match = cmp_valid && (rd_data.ip == item_ip);
  assign older = (cmp_idx == '0) || (rd_data.stamp < min_stamp);

  // Table write on add: rewrite the hit entry, fill the next free slot or evict
  assign wr_en        = (state == ST_DECIDE) && (item_op == arpc_pkg::OP_ADD);
  assign wr_data.ip    = item_ip;
  assign wr_data.mac   = item_mac;
  assign wr_data.stamp = item_now;

  always_comb begin
    if (found) begin
      wr_addr = found_idx;
    end else if (!table_full) begin
      wr_addr = fill_count[IDX_W-1:0];
    end else begin
      wr_addr = min_idx;
    end
  end

  arpc_table_ram #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_count  <= '0;
      out_valid   <= 1'b0;
      local_ip    <= '0;
      subnet_mask <= '0;
      cmp_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[2])
          arpc_pkg::REG_LOCAL_IP:    local_ip <= pwdata;
          arpc_pkg::REG_SUBNET_MASK: subnet_mask <= pwdata;
          default: ;
        endcase
      end

      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      cmp_valid <= issue;

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= (opcode == arpc_pkg::OP_RESOLVE &&
                      (ip_address == arpc_pkg::IP_ALL_ONES || ip_address == subnet_bcast))
                     ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Stop on the first hit, or once every valid entry has been compared
          if (match || (!issue && !cmp_valid)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (item_op == arpc_pkg::OP_ADD && !item_bcast && !found && !table_full) begin
            fill_count <= fill_count + CNT_W'(1);
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Transaction payload, scan tracking and result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_op    <= opcode;
      item_ip    <= ip_address;
      item_mac   <= mac_address;
      item_now   <= now_ticks;
      item_bcast <= (opcode == arpc_pkg::OP_RESOLVE) &&
                    (ip_address == arpc_pkg::IP_ALL_ONES || ip_address == subnet_bcast);
      found      <= 1'b0;
      scan_idx   <= '0;
    end

    if (issue) begin
      scan_idx <= scan_idx + CNT_W'(1);
      cmp_idx  <= scan_idx[IDX_W-1:0];
    end

    if (state == ST_SCAN && cmp_valid) begin
      if (match) begin
        found     <= 1'b1;
        found_idx <= cmp_idx;
        res_mac   <= rd_data.mac;
      end
      if (older) begin
        min_stamp <= rd_data.stamp;
        min_idx   <= cmp_idx;
      end
    end

    if (state == ST_DECIDE) begin
      if (item_op == arpc_pkg::OP_RESOLVE) begin
        if (item_bcast) begin
          res_status <= arpc_pkg::STAT_BCAST;
          res_mac    <= arpc_pkg::MAC_ALL_ONES;
          res_slot   <= '0;
        end else if (found) begin
          res_status <= arpc_pkg::STAT_HIT;
          res_slot   <= arpc_pkg::SLOT_W'(found_idx);
        end else begin
          res_status <= arpc_pkg::STAT_MISS;
          res_mac    <= '0;
          res_slot   <= '0;
        end
      end else begin
        res_mac <= '0;
        if (found) begin
          res_status <= arpc_pkg::STAT_UPDATED;
          res_slot   <= arpc_pkg::SLOT_W'(found_idx);
        end else if (!table_full) begin
          res_status <= arpc_pkg::STAT_INSERTED;
          res_slot   <= arpc_pkg::SLOT_W'(fill_count);
        end else begin
          res_status <= arpc_pkg::STAT_EVICTED;
          res_slot   <= arpc_pkg::SLOT_W'(min_idx);
        end
      end
    end

    if (state == ST_FIN && out_free) begin
      status     <= res_status;
      mac_result <= res_mac;
      slot       <= res_slot;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/arpc_table_ram.sv =====
// Table memory: one write port, one registered read port.
`default_nettype none
module arpc_table_ram #(
  parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire arpc_pkg::entry_t wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output arpc_pkg::entry_t      rd_data
);

  arpc_pkg::entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
